@@ rtl/mia_pkg.sv @@
// ----------------------------------------------------------------------------
// mia_pkg: shared definitions for the adjugate matrix inverse
// Widths, fixed-point constants and the sequencer state type.
// ----------------------------------------------------------------------------
package mia_pkg;

  localparam int MAX_DIM     = 4;
  localparam int FRAC_BITS   = 16;
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int LCNT_W      = $clog2(STORE_DEPTH + 1);
  localparam int IDX_W       = $clog2(MAX_DIM);
  localparam int DIM_W       = $clog2(MAX_DIM + 1);
  localparam int CFG_W       = 3;
  localparam int OUT_IDX_W   = 2;
  localparam int ELEM_W      = 32;
  localparam int ACC_W       = 64;
  localparam int HALF_W      = 32;
  localparam int SUM_W       = ACC_W + ELEM_W + 1;
  localparam int DVD_W       = ACC_W + FRAC_BITS;
  localparam int DIV_CNT_W   = $clog2(DVD_W + 1);
  localparam int QUO_W       = ELEM_W + 1;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(4);

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] ELEM_MAX_X =
    {{(ACC_W-ELEM_W+1){1'b0}}, {(ELEM_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ELEM_MIN_X =
    {{(ACC_W-ELEM_W+1){1'b1}}, {(ELEM_W-1){1'b0}}};

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_DET_INIT,
    ST_DESCEND,
    ST_LEAF_WAIT,
    ST_RETURN,
    ST_RDELEM,
    ST_MUL_START,
    ST_MUL_WAIT,
    ST_ACC,
    ST_DET_DONE,
    ST_ENTRY,
    ST_COF_DONE,
    ST_DIV_WAIT,
    ST_OUT
  } state_t;

endpackage

@@ rtl/mia_ram.sv @@
// ----------------------------------------------------------------------------
// mia_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mia_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/mia_mulq.sv @@
// ----------------------------------------------------------------------------
// mia_mulq: multi-cycle fixed-point multiplier
// Multiplies a 32-bit element by a 64-bit value on one 32x32 multiplier,
// rounds half away from zero at the fraction point and saturates.
// ----------------------------------------------------------------------------
module mia_mulq (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [mia_pkg::ELEM_W-1:0]   a,
  input  logic signed [mia_pkg::ACC_W-1:0]    b,
  input  logic                                neg,
  output logic                                done,
  output logic signed [mia_pkg::ACC_W-1:0]    prod,
  output logic                                ovf
);
  import mia_pkg::*;

  logic [ELEM_W-1:0]    ua;
  logic [ACC_W-1:0]     ub;
  logic                 negative;
  logic [3:0]           phase;
  logic [ACC_W-1:0]     p0;
  logic [ACC_W-1:0]     p1;
  logic [SUM_W-1:0]     sum;
  logic [HALF_W-1:0]    mb;
  logic [ACC_W-1:0]     mp;
  logic [ACC_W-1:0]     m;
  logic [ACC_W-1:0]     limit;
  logic                 over;
  logic [ACC_W-1:0]     msat;

  assign mb = phase[0] ? ub[HALF_W-1:0] : ub[ACC_W-1:HALF_W];
  assign mp = ACC_W'(ua) * ACC_W'(mb);

  assign m     = sum[FRAC_BITS +: ACC_W];
  assign limit = negative ? ACC_W'(ACC_MIN) : ACC_W'(ACC_MAX);
  assign over  = (sum[SUM_W-1:ACC_W+FRAC_BITS] != '0) || (m > limit);
  assign msat  = over ? limit : m;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      done  <= 1'b0;
    end else begin
      phase <= {phase[2:0], start};
      done  <= phase[3];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ua       <= a[ELEM_W-1] ? ELEM_W'(-a) : ELEM_W'(a);
      ub       <= b[ACC_W-1] ? ACC_W'(-b) : ACC_W'(b);
      negative <= (a[ELEM_W-1] ^ b[ACC_W-1]) ^ neg;
    end
    if (phase[0]) begin
      p0 <= mp;
    end
    if (phase[1]) begin
      p1 <= mp;
    end
    if (phase[2]) begin
      sum <= SUM_W'({p1, {HALF_W{1'b0}}}) + SUM_W'(p0) + (SUM_W'(1) << (FRAC_BITS - 1));
    end
    if (phase[3]) begin
      prod <= negative ? -$signed(msat) : $signed(msat);
      ovf  <= over;
    end
  end

endmodule

@@ rtl/mia_divq.sv @@
// ----------------------------------------------------------------------------
// mia_divq: serial fixed-point divider
// Restoring division of a cofactor shifted by the fraction bits by the
// determinant, one quotient bit per cycle, rounded and saturated to 32 bits.
// ----------------------------------------------------------------------------
module mia_divq (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [mia_pkg::ACC_W-1:0]    num,
  input  logic signed [mia_pkg::ACC_W-1:0]    den,
  output logic                                done,
  output logic signed [mia_pkg::ELEM_W-1:0]   quo,
  output logic                                ovf
);
  import mia_pkg::*;

  logic [ACC_W-1:0]     ud;
  logic [DVD_W-1:0]     dvd;
  logic [ACC_W-1:0]     rem;
  logic [QUO_W-1:0]     q;
  logic                 big;
  logic                 negative;
  logic                 busy;
  logic                 fin;
  logic [DIV_CNT_W-1:0] cnt;
  logic [ACC_W:0]       rem_sh;
  logic                 ge;
  logic [ACC_W:0]       rem_sub;
  logic                 rnd;
  logic [QUO_W:0]       qr;
  logic [QUO_W:0]       lim;
  logic                 over;
  logic [QUO_W:0]       qsat;

  assign rem_sh  = {rem, dvd[DVD_W-1]};
  assign ge      = rem_sh >= {1'b0, ud};
  assign rem_sub = rem_sh - {1'b0, ud};

  assign rnd  = {rem, 1'b0} >= {1'b0, ud};
  assign qr   = {1'b0, q} + (QUO_W+1)'(rnd);
  assign lim  = negative ? ((QUO_W+1)'(1) << (ELEM_W - 1))
                         : ((QUO_W+1)'(1) << (ELEM_W - 1)) - (QUO_W+1)'(1);
  assign over = big || (qr > lim);
  assign qsat = over ? lim : qr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= fin;
      fin  <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
        fin  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ud       <= den[ACC_W-1] ? ACC_W'(-den) : ACC_W'(den);
      dvd      <= {(num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num)), {FRAC_BITS{1'b0}}};
      rem      <= '0;
      q        <= '0;
      big      <= 1'b0;
      negative <= num[ACC_W-1] ^ den[ACC_W-1];
      cnt      <= DIV_CNT_W'(DVD_W);
    end else if (busy) begin
      rem <= ge ? rem_sub[ACC_W-1:0] : rem_sh[ACC_W-1:0];
      dvd <= dvd << 1;
      cnt <= cnt - DIV_CNT_W'(1);
      if (q[QUO_W-1]) begin
        big <= 1'b1;
      end else begin
        q <= {q[QUO_W-2:0], ge};
      end
    end
    if (fin) begin
      quo <= negative ? -$signed(qsat[ELEM_W-1:0]) : $signed(qsat[ELEM_W-1:0]);
      ovf <= over;
    end
  end

endmodule

@@ rtl/matrix_inverse_adjugate.sv @@
// ----------------------------------------------------------------------------
// matrix_inverse_adjugate: square matrix inverse by the adjugate
// Loads a matrix in row-major order, expands its determinant along the first
// row on a shared multiplier and, if it is nonzero, each cofactor likewise,
// divides each by the determinant on a serial divider and emits the inverse.
//
//   Channel   Signals                         Direction  Transaction
//   cfg       cfg_valid cfg_ready mat_size    in         matrix dimension
//   in        in_valid in_ready elem          in         one matrix element
//   out       out_valid out_ready inv_value   out        one inverse entry
//             row_idx col_idx det_value
//             singular overflow last
//
// Each element is taken in one cycle while loading.
// After the last element the cofactor expansion runs one product at a time
// on the shared multiplier; each inverse entry then uses the serial divider.
// Input is not accepted during the computation; an entry waiting in the
// output register stalls the next entry's computation only at hand-off.
// Reset is synchronous and sets the dimension to 4.
// ----------------------------------------------------------------------------
module matrix_inverse_adjugate (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [mia_pkg::CFG_W-1:0]             mat_size,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [mia_pkg::ELEM_W-1:0]     elem,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [mia_pkg::ELEM_W-1:0]     inv_value,
  output logic [mia_pkg::OUT_IDX_W-1:0]         row_idx,
  output logic [mia_pkg::OUT_IDX_W-1:0]         col_idx,
  output logic signed [mia_pkg::ELEM_W-1:0]     det_value,
  output logic                                  singular,
  output logic                                  overflow,
  output logic                                  last
);
  import mia_pkg::*;

  state_t                   state;
  state_t                   state_next;
  logic [CFG_W-1:0]         msize;
  logic [LCNT_W-1:0]        load_count;
  logic [DIM_W-1:0]         ndim;
  logic [LCNT_W-1:0]        total;
  logic                     final_elem;
  logic [MAX_DIM-1:0]       full_mask;

  logic [IDX_W-1:0]         lvl;
  logic [IDX_W-1:0]         klast;
  logic                     mode_cof;
  logic signed [ACC_W-1:0]  acc [MAX_DIM];
  logic [IDX_W-1:0]         cur [MAX_DIM];
  logic [MAX_DIM-1:0]       par;
  logic [MAX_DIM-1:0]       cmask [MAX_DIM];
  logic signed [ACC_W-1:0]  ret_val;
  logic                     ov;

  logic signed [ACC_W-1:0]  det;
  logic signed [ELEM_W-1:0] det_out;
  logic                     det_ov;
  logic                     det_zero;
  logic [IDX_W-1:0]         r_idx;
  logic [IDX_W-1:0]         c_idx;
  logic signed [ELEM_W-1:0] ent_val;
  logic                     ent_ov;

  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_raddr;
  logic [ELEM_W-1:0]        ram_rdata;
  logic                     mul_start;
  logic                     mul_done;
  logic signed [ACC_W-1:0]  mul_prod;
  logic                     mul_ov;
  logic                     div_start;
  logic                     div_done;
  logic signed [ELEM_W-1:0] div_quo;
  logic                     div_ov;
  logic                     out_free;
  logic                     out_load;

  logic                     leaf;
  logic [IDX_W-1:0]         lo_bit;
  logic [IDX_W:0]           lo_pick;
  logic [IDX_W:0]           nb;
  logic [IDX_W-1:0]         row_l;
  logic [ACC_W:0]           add_res;
  logic                     odd;
  logic signed [ACC_W-1:0]  cof_num;
  logic                     neg_ov;
  logic                     is_last;
  logic signed [ACC_W-1:0]  rd_ext;
  logic [IDX_W+1:0]         r_ext;
  logic [IDX_W+1:0]         c_ext;

  function automatic logic [IDX_W:0] next_above(input logic [MAX_DIM-1:0] m,
                                                input logic [IDX_W-1:0] after,
                                                input logic any);
    logic [IDX_W:0] res;
    res = '0;
    for (int t = MAX_DIM - 1; t >= 0; t--) begin
      if (m[t] && (any || t > int'(after))) begin
        res = {1'b1, IDX_W'(t)};
      end
    end
    return res;
  endfunction

  function automatic logic [ACC_W:0] sat_add(input logic signed [ACC_W-1:0] x,
                                             input logic signed [ACC_W-1:0] y);
    logic signed [ACC_W-1:0] s;
    logic [ACC_W:0]          res;
    s = x + y;
    res = {1'b0, s};
    if (!x[ACC_W-1] && !y[ACC_W-1] && s[ACC_W-1]) begin
      res = {1'b1, ACC_MAX};
    end else if (x[ACC_W-1] && y[ACC_W-1] && !s[ACC_W-1]) begin
      res = {1'b1, ACC_MIN};
    end
    return res;
  endfunction

  function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] row,
                                                  input logic [IDX_W-1:0] col,
                                                  input logic [DIM_W-1:0] n);
    return ADDR_W'(row) * ADDR_W'(n) + ADDR_W'(col);
  endfunction

  always_comb begin
    if (msize < CFG_W'(2)) begin
      ndim = DIM_W'(2);
    end else if (int'(msize) > MAX_DIM) begin
      ndim = DIM_W'(MAX_DIM);
    end else begin
      ndim = DIM_W'(msize);
    end
  end

  always_comb begin
    for (int t = 0; t < MAX_DIM; t++) begin
      full_mask[t] = t < int'(ndim);
    end
  end

  assign total      = LCNT_W'(ndim) * LCNT_W'(ndim);
  assign final_elem = (load_count + LCNT_W'(1)) >= total;

  assign leaf    = lvl == klast;
  assign nb      = next_above(cmask[lvl], cur[lvl], 1'b0);
  assign lo_pick = next_above(cmask[lvl], cur[lvl], 1'b1);
  assign lo_bit  = lo_pick[IDX_W-1:0];
  assign row_l   = (mode_cof && lvl >= c_idx) ? lvl + IDX_W'(1) : lvl;
  assign add_res = sat_add(acc[lvl], mul_prod);
  assign rd_ext  = {{(ACC_W-ELEM_W){ram_rdata[ELEM_W-1]}}, ram_rdata};

  assign odd     = r_idx[0] ^ c_idx[0];
  assign neg_ov  = odd && (ret_val == ACC_MIN);
  assign cof_num = !odd ? ret_val : (neg_ov ? ACC_MAX : -ret_val);
  assign is_last = (r_idx == IDX_W'(ndim - DIM_W'(1))) &&
                   (c_idx == IDX_W'(ndim - DIM_W'(1)));
  assign out_free = !out_valid || out_ready;
  assign r_ext    = (IDX_W+2)'(r_idx);
  assign c_ext    = (IDX_W+2)'(c_idx);

  assign cfg_ready = 1'b1;

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (in_valid && final_elem) begin
          state_next = ST_DET_INIT;
        end
      end
      ST_DET_INIT:  state_next = ST_DESCEND;
      ST_DESCEND: begin
        if (leaf) begin
          state_next = ST_LEAF_WAIT;
        end
      end
      ST_LEAF_WAIT: state_next = ST_RETURN;
      ST_RETURN: begin
        if (lvl == '0) begin
          state_next = mode_cof ? ST_COF_DONE : ST_DET_DONE;
        end else begin
          state_next = ST_RDELEM;
        end
      end
      ST_RDELEM:    state_next = ST_MUL_START;
      ST_MUL_START: state_next = ST_MUL_WAIT;
      ST_MUL_WAIT: begin
        if (mul_done) begin
          state_next = ST_ACC;
        end
      end
      ST_ACC:       state_next = nb[IDX_W] ? ST_DESCEND : ST_RETURN;
      ST_DET_DONE:  state_next = ST_ENTRY;
      ST_ENTRY:     state_next = det_zero ? ST_OUT : ST_DESCEND;
      ST_COF_DONE:  state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_next = is_last ? ST_LOAD : ST_ENTRY;
        end
      end
      default:      state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    ram_raddr = elem_addr(row_l, cur[lvl], ndim);
    case (state)
      ST_LOAD:      in_ready = 1'b1;
      ST_DESCEND:   ram_raddr = elem_addr(row_l, lo_bit, ndim);
      ST_MUL_START: mul_start = 1'b1;
      ST_COF_DONE:  div_start = 1'b1;
      ST_OUT:       out_load = out_free;
      default: begin
      end
    endcase
  end

  assign ram_we = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      msize      <= CFG_RESET;
      load_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        msize      <= mat_size;
        load_count <= '0;
      end else if (ram_we) begin
        load_count <= final_elem ? '0 : load_count + LCNT_W'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_DET_INIT: begin
        lvl      <= '0;
        mode_cof <= 1'b0;
        ov       <= 1'b0;
        cmask[0] <= full_mask;
        klast    <= IDX_W'(ndim - DIM_W'(1));
      end
      ST_DESCEND: begin
        if (!leaf) begin
          cur[lvl]                 <= lo_bit;
          par[lvl]                 <= 1'b0;
          acc[lvl]                 <= '0;
          cmask[lvl + IDX_W'(1)]   <= cmask[lvl] & ~(MAX_DIM'(1) << lo_bit);
          lvl                      <= lvl + IDX_W'(1);
        end
      end
      ST_LEAF_WAIT: ret_val <= rd_ext;
      ST_RETURN: begin
        if (lvl != '0) begin
          lvl <= lvl - IDX_W'(1);
        end
      end
      ST_ACC: begin
        ov <= ov | mul_ov | add_res[ACC_W];
        if (nb[IDX_W]) begin
          acc[lvl]               <= add_res[ACC_W-1:0];
          cur[lvl]               <= nb[IDX_W-1:0];
          par[lvl]               <= ~par[lvl];
          cmask[lvl + IDX_W'(1)] <= cmask[lvl] & ~(MAX_DIM'(1) << nb[IDX_W-1:0]);
          lvl                    <= lvl + IDX_W'(1);
        end else begin
          ret_val <= add_res[ACC_W-1:0];
        end
      end
      ST_DET_DONE: begin
        det      <= ret_val;
        det_zero <= ret_val == '0;
        r_idx    <= '0;
        c_idx    <= '0;
        if (ret_val > ELEM_MAX_X) begin
          det_out <= ELEM_MAX_X[ELEM_W-1:0];
          det_ov  <= 1'b1;
        end else if (ret_val < ELEM_MIN_X) begin
          det_out <= ELEM_MIN_X[ELEM_W-1:0];
          det_ov  <= 1'b1;
        end else begin
          det_out <= ret_val[ELEM_W-1:0];
          det_ov  <= ov;
        end
      end
      ST_ENTRY: begin
        if (det_zero) begin
          ent_val <= '0;
          ent_ov  <= det_ov;
        end else begin
          lvl      <= '0;
          mode_cof <= 1'b1;
          ov       <= det_ov;
          cmask[0] <= full_mask & ~(MAX_DIM'(1) << r_idx);
          klast    <= IDX_W'(ndim - DIM_W'(2));
        end
      end
      ST_COF_DONE: ent_ov <= ov | neg_ov;
      ST_DIV_WAIT: begin
        if (div_done) begin
          ent_val <= div_quo;
          ent_ov  <= ent_ov | div_ov;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          inv_value <= ent_val;
          row_idx   <= r_ext[OUT_IDX_W-1:0];
          col_idx   <= c_ext[OUT_IDX_W-1:0];
          det_value <= det_out;
          singular  <= det_zero;
          overflow  <= ent_ov;
          last      <= is_last;
          if (c_idx == IDX_W'(ndim - DIM_W'(1))) begin
            c_idx <= '0;
            r_idx <= r_idx + IDX_W'(1);
          end else begin
            c_idx <= c_idx + IDX_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  mia_ram #(
    .WIDTH(ELEM_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (load_count[ADDR_W-1:0]),
    .wdata (elem),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mia_mulq u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     ($signed(ram_rdata)),
    .b     (ret_val),
    .neg   (par[lvl]),
    .done  (mul_done),
    .prod  (mul_prod),
    .ovf   (mul_ov)
  );

  mia_divq u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (cof_num),
    .den   (det),
    .done  (div_done),
    .quo   (div_quo),
    .ovf   (div_ov)
  );

endmodule
